### sv/utrl_pkg.sv
// Shared types and constants of the unibit trie route lookup engine.
`default_nettype none
package utrl_pkg;

   localparam int NODE_COUNT_DEFAULT = 4096;
   localparam int ADDR_W             = 32;
   localparam int PLEN_W             = 6;
   localparam int HOP_W              = 32;
   localparam int REQ_DATA_W         = 72;
   localparam int RSP_DATA_W         = 32;

   // Field placement inside req_tdata.
   localparam int REQ_ADDR_LSB       = 0;
   localparam int REQ_PLEN_LSB       = REQ_ADDR_LSB + ADDR_W;
   localparam int REQ_HOP_LSB        = REQ_PLEN_LSB + PLEN_W;

   typedef enum logic {
      ACTION_INSERT = 1'b0,
      ACTION_LOOKUP = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_MISS = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROOT,
      ST_EXAMINE,
      ST_ALLOC,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

### sv/unibit_trie_route_lookup.sv
// Top level of the IPv4 longest-prefix-match engine on a unibit trie.
//
// The engine keeps a binary trie in one node memory of NODE_COUNT entries and
// handles one request at a time. An insert walks the top prefix_len bits of the
// address from the root (node 0), takes a missing child from a bump counter and
// marks the last node terminal with the next hop; a repeat insert of the same
// prefix overwrites that hop. A lookup walks up to 32 address bits and returns
// the hop of the deepest terminal node it passes, or a miss. The node read for
// the next trie level is issued in the same cycle that examines the current
// one. Each newly allocated level of an insert takes a link write into the
// parent and a clearing write of the new node, both through the single write
// port of the node memory. No clearing pass is needed after reset: nodes are
// written in full when allocated and only allocated nodes are read. A new
// request is taken once the previous result has been posted to the output
// register, even while that result still waits for rsp_tready. When the pool
// is exhausted an insert ends with status 2 (pool full); nodes allocated
// before that point stay.
`default_nettype none
module unibit_trie_route_lookup #(
   parameter int NODE_COUNT = utrl_pkg::NODE_COUNT_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // tdata fields from bit 0 up: address[31:0], prefix_len[5:0], hop_in[31:0], pad
   input  wire logic [utrl_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser fields: action (0 insert, 1 lookup)
   input  wire logic                            req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // tdata fields from bit 0 up: hop_out[31:0]
   output logic      [utrl_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // tuser fields: status (0 ok/hit, 1 miss, 2 pool full)
   output logic      [1:0]                      rsp_tuser
);

   localparam int IDX_W  = $clog2(NODE_COUNT);
   localparam int CNT_W  = IDX_W + 1;
   // Node layout from bit 0 up: zero child, one child, next hop, terminal flag.
   localparam int ONE_LSB  = IDX_W;
   localparam int HOP_LSB  = 2 * IDX_W;
   localparam int TERM_BIT = HOP_LSB + utrl_pkg::HOP_W;
   localparam int NODE_W   = TERM_BIT + 1;

   // Walk state.
   utrl_pkg::state_type                state_ff, state_in;
   utrl_pkg::action_type               action_ff, action_in;
   logic [utrl_pkg::ADDR_W-1:0]        addr_ff, addr_in;    // shifted left per level
   logic [utrl_pkg::PLEN_W-1:0]        plen_ff, plen_in;
   logic [utrl_pkg::PLEN_W-1:0]        depth_ff, depth_in;
   logic [utrl_pkg::HOP_W-1:0]         hop_ff, hop_in;
   logic [IDX_W-1:0]                   cur_ff, cur_in;
   logic                               fresh_ff, fresh_in;  // current node known all-zero
   logic [CNT_W-1:0]                   used_ff, used_in;
   utrl_pkg::status_type               res_status_ff, res_status_in;
   logic [utrl_pkg::HOP_W-1:0]         res_hop_ff, res_hop_in;

   // Output register.
   logic                               rsp_valid_ff, rsp_valid_in;
   utrl_pkg::status_type               rsp_status_ff, rsp_status_in;
   logic [utrl_pkg::HOP_W-1:0]         rsp_hop_ff, rsp_hop_in;

   // Node memory ports.
   logic                               wr_en;
   logic [IDX_W-1:0]                   wr_addr;
   logic [NODE_W-1:0]                  wr_data;
   logic                               rd_en;
   logic [IDX_W-1:0]                   rd_addr;
   logic [NODE_W-1:0]                  rd_data;

   // Decode of the node under examination.
   logic [NODE_W-1:0]                  node;
   logic [IDX_W-1:0]                   child;
   logic                               take_one;
   logic                               pool_full;
   logic                               trie_empty;
   logic                               accept;
   logic                               post;
   logic [utrl_pkg::PLEN_W-1:0]        req_plen;

   utrl_ram #(
      .WIDTH (NODE_W),
      .DEPTH (NODE_COUNT)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == utrl_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   // The result register may be loaded when it is empty or being drained.
   assign post       = (state_ff == utrl_pkg::ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // A freshly allocated node has not been read back; it is known to be all zero.
   assign node       = fresh_ff ? '0 : rd_data;
   assign take_one   = addr_ff[utrl_pkg::ADDR_W-1];
   assign child      = take_one ? node[ONE_LSB +: IDX_W] : node[IDX_W-1:0];
   assign pool_full  = (used_ff == CNT_W'(NODE_COUNT));
   assign trie_empty = (used_ff == '0);

   // Prefix lengths above 32 behave as 32.
   assign req_plen = (req_tdata[utrl_pkg::REQ_PLEN_LSB +: utrl_pkg::PLEN_W] >
                      utrl_pkg::PLEN_W'(utrl_pkg::ADDR_W))
                     ? utrl_pkg::PLEN_W'(utrl_pkg::ADDR_W)
                     : req_tdata[utrl_pkg::REQ_PLEN_LSB +: utrl_pkg::PLEN_W];

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         utrl_pkg::ST_IDLE: begin
            if (accept) begin
               if (!trie_empty) begin
                  state_in = utrl_pkg::ST_EXAMINE;
               end else if (utrl_pkg::action_type'(req_tuser) == utrl_pkg::ACTION_INSERT) begin
                  state_in = utrl_pkg::ST_ROOT;
               end else begin
                  state_in = utrl_pkg::ST_DONE;
               end
            end
         end
         utrl_pkg::ST_ROOT: begin
            state_in = utrl_pkg::ST_EXAMINE;
         end
         utrl_pkg::ST_EXAMINE: begin
            if (action_ff == utrl_pkg::ACTION_LOOKUP) begin
               if (depth_ff == utrl_pkg::PLEN_W'(utrl_pkg::ADDR_W) || child == '0) begin
                  state_in = utrl_pkg::ST_DONE;
               end
            end else if (depth_ff == plen_ff) begin
               state_in = utrl_pkg::ST_DONE;
            end else if (child == '0) begin
               state_in = pool_full ? utrl_pkg::ST_DONE : utrl_pkg::ST_ALLOC;
            end
         end
         utrl_pkg::ST_ALLOC: begin
            state_in = utrl_pkg::ST_EXAMINE;
         end
         utrl_pkg::ST_DONE: begin
            if (post) begin
               state_in = utrl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = utrl_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath, memory control and result register.
   always_comb begin
      action_in     = action_ff;
      addr_in       = addr_ff;
      plen_in       = plen_ff;
      depth_in      = depth_ff;
      hop_in        = hop_ff;
      cur_in        = cur_ff;
      fresh_in      = fresh_ff;
      used_in       = used_ff;
      res_status_in = res_status_ff;
      res_hop_in    = res_hop_ff;
      wr_en         = 1'b0;
      wr_addr       = cur_ff;
      wr_data       = node;
      rd_en         = 1'b0;
      rd_addr       = child;
      rsp_status_in = rsp_status_ff;
      rsp_hop_in    = rsp_hop_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      case (state_ff)
         utrl_pkg::ST_IDLE: begin
            if (accept) begin
               action_in  = utrl_pkg::action_type'(req_tuser);
               addr_in    = req_tdata[utrl_pkg::REQ_ADDR_LSB +: utrl_pkg::ADDR_W];
               plen_in    = req_plen;
               hop_in     = req_tdata[utrl_pkg::REQ_HOP_LSB +: utrl_pkg::HOP_W];
               depth_in   = '0;
               cur_in     = '0;
               fresh_in   = 1'b0;
               res_hop_in = '0;
               res_status_in = (utrl_pkg::action_type'(req_tuser) == utrl_pkg::ACTION_LOOKUP)
                               ? utrl_pkg::STATUS_MISS : utrl_pkg::STATUS_OK;
               // Fetch the root straight away; it is examined next cycle.
               rd_en   = !trie_empty;
               rd_addr = '0;
            end
         end
         utrl_pkg::ST_ROOT: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = '0;
            used_in  = CNT_W'(1);
            cur_in   = '0;
            fresh_in = 1'b1;
         end
         utrl_pkg::ST_EXAMINE: begin
            if (action_ff == utrl_pkg::ACTION_LOOKUP) begin
               if (node[TERM_BIT]) begin
                  res_status_in = utrl_pkg::STATUS_OK;
                  res_hop_in    = node[HOP_LSB +: utrl_pkg::HOP_W];
               end
               if (depth_ff != utrl_pkg::PLEN_W'(utrl_pkg::ADDR_W) && child != '0) begin
                  rd_en    = 1'b1;
                  cur_in   = child;
                  depth_in = depth_ff + 1'b1;
                  addr_in  = addr_ff << 1;
                  fresh_in = 1'b0;
               end
            end else if (depth_ff == plen_ff) begin
               // End of the prefix: mark terminal, keep both child links.
               wr_en   = 1'b1;
               wr_data = {1'b1, hop_ff, node[HOP_LSB-1:0]};
            end else if (child != '0) begin
               rd_en    = 1'b1;
               cur_in   = child;
               depth_in = depth_ff + 1'b1;
               addr_in  = addr_ff << 1;
               fresh_in = 1'b0;
            end else if (pool_full) begin
               res_status_in = utrl_pkg::STATUS_FULL;
            end else begin
               // Link the node about to be allocated into the parent.
               wr_en   = 1'b1;
               wr_data = node;
               if (take_one) begin
                  wr_data[ONE_LSB +: IDX_W] = used_ff[IDX_W-1:0];
               end else begin
                  wr_data[IDX_W-1:0] = used_ff[IDX_W-1:0];
               end
            end
         end
         utrl_pkg::ST_ALLOC: begin
            wr_en    = 1'b1;
            wr_addr  = used_ff[IDX_W-1:0];
            wr_data  = '0;
            cur_in   = used_ff[IDX_W-1:0];
            used_in  = used_ff + 1'b1;
            depth_in = depth_ff + 1'b1;
            addr_in  = addr_ff << 1;
            fresh_in = 1'b1;
         end
         utrl_pkg::ST_DONE: begin
            if (post) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_hop_in    = res_hop_ff;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_tready;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= utrl_pkg::ST_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      addr_ff       <= addr_in;
      plen_ff       <= plen_in;
      depth_ff      <= depth_in;
      hop_ff        <= hop_in;
      cur_ff        <= cur_in;
      fresh_ff      <= fresh_in;
      res_status_ff <= res_status_in;
      res_hop_ff    <= res_hop_in;
      rsp_status_ff <= rsp_status_in;
      rsp_hop_ff    <= rsp_hop_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_hop_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule
`default_nettype wire

### sv/utrl_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module utrl_ram #(
   parameter int WIDTH = utrl_pkg::HOP_W,
   parameter int DEPTH = utrl_pkg::NODE_COUNT_DEFAULT,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

### sv/utrl_checker.sv
// Port-level checker for the route lookup engine and its bind to the top level.
`default_nettype none
module utrl_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic [utrl_pkg::REQ_DATA_W-1:0] req_tdata,
   input wire logic                            req_tuser,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [utrl_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [1:0]                      rsp_tuser
);

   // A waiting result keeps its contents until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // Only one request is in the engine at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // Misses and pool-full results carry a zero next hop.
   a_zero_hop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == utrl_pkg::STATUS_MISS || rsp_tuser == utrl_pkg::STATUS_FULL)
      |-> rsp_tdata == '0)
      else $error("nonzero hop on a miss or full result");

   // Reset leaves the engine idle with no pending result.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("engine not idle after reset");

   // The request payload is not examined here.
   logic unused_req;
   assign unused_req = ^{req_tdata, req_tuser};

endmodule

bind unibit_trie_route_lookup utrl_checker u_utrl_checker (.*);
`default_nettype wire
